FILE: rtl/thermistor_adc_to_temperature_core_defines.svh
// Assertion macros used by the checker file of the thermistor core.
// No dependencies; include by bare file name.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TATC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay, disabled while reset is low.
`define TATC_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

FILE: rtl/tatc_pkg.sv
// Shared widths, latencies and status codes of the thermistor conversion core.
// No dependencies.
package tatc_pkg;

    localparam int ADC_BITS      = 12;
    localparam int LOG_FRAC_BITS = 16;
    localparam int NORM_BITS     = 30;
    localparam int BIAS_W        = 20;
    localparam int MV_W          = 14;
    localparam int NW            = ADC_BITS + MV_W;
    localparam int XW            = BIAS_W + NW;
    localparam int PW            = $clog2(XW);
    localparam int LGW           = PW + LOG_FRAC_BITS;
    localparam int LOG_LAT       = LOG_FRAC_BITS + 2;
    localparam int DIV_STEPS     = 18;
    localparam int ST_OUT        = 2 + LOG_LAT + 10 + DIV_STEPS + 5;
    localparam int PIPE_LAT      = ST_OUT + 1;
    localparam int TEMP_W        = 18;
    localparam int TEMP_MAX      = 100000;
    localparam int TEMP_MIN      = -100000;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_HIGH = 2'd2;

endpackage

FILE: rtl/tatc_log2.sv
// Pipelined fixed-point log2: priority encode, normalize, one squaring per stage.
// Depends on tatc_pkg.
module tatc_log2 (
    input  logic                     i_clk,
    input  logic [tatc_pkg::XW-1:0]  i_x,
    output logic [tatc_pkg::LGW-1:0] o_log
);

    localparam int XW  = tatc_pkg::XW;
    localparam int PW  = tatc_pkg::PW;
    localparam int LFB = tatc_pkg::LOG_FRAC_BITS;
    localparam int NB  = tatc_pkg::NORM_BITS;
    localparam int MW  = NB + 1;

    function automatic logic [PW-1:0] lead_one(input logic [XW-1:0] x);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 1; i < XW; i++) begin
            if (x[i]) p = PW'(i);
        end
        return p;
    endfunction

    logic [XW-1:0]  r_x;
    logic [PW-1:0]  r_p;
    logic [MW-1:0]  r_m  [0:LFB];
    logic [LFB-1:0] r_fr [0:LFB];
    logic [PW-1:0]  r_pl [0:LFB];

    logic [XW-1:0]   n_al;
    logic [2*MW-1:0] n_sq [1:LFB];
    logic [MW:0]     n_m2 [1:LFB];

    always_comb begin
        n_al = r_x << (PW'(XW - 1) - r_p);
        for (int k = 1; k <= LFB; k++) begin
            n_sq[k] = (2*MW)'(r_m[k-1]) * (2*MW)'(r_m[k-1]);
            n_m2[k] = n_sq[k][2*MW-1:NB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= i_x;
        r_p     <= lead_one(i_x);
        r_m[0]  <= n_al[XW-1 -: MW];
        r_fr[0] <= '0;
        r_pl[0] <= r_p;
        for (int k = 1; k <= LFB; k++) begin
            // square, renormalize when it reaches two, shift the bit in
            if (n_m2[k][MW]) begin
                r_m[k]  <= n_m2[k][MW:1];
                r_fr[k] <= {r_fr[k-1][LFB-2:0], 1'b1};
            end else begin
                r_m[k]  <= n_m2[k][MW-1:0];
                r_fr[k] <= {r_fr[k-1][LFB-2:0], 1'b0};
            end
            r_pl[k] <= r_pl[k-1];
        end
    end

    assign o_log = {r_pl[LFB], r_fr[LFB]};

endmodule

FILE: rtl/thermistor_adc_to_temperature_core.sv
// Top level: thermistor divider ADC code to temperature, Steinhart-Hart, fixed point.
// Depends on tatc_pkg and tatc_log2.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  sample   | start in, busy out       | i_adc_code[11:0]
//  result   | o_done strobe, one cycle | o_temp_centi[17:0] s, o_status[1:0]
//  config   | i_cfg_we                 | i_cfg_addr[1:0], i_cfg_wdata[19:0]
//
// One sample beat per cycle; busy stays low. The delay from a sample to its result is
// set by the 16 squaring stages of the log2 units and the 18
// quotient-bit stages of the reciprocal divider, plus the surrounding multiply
// stages. Synchronous active-low reset clears the valid line and presets the configuration
// registers. Results cannot be stalled by the receiver; the pipeline advances every cycle.
module thermistor_adc_to_temperature_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [11:0]                         i_adc_code,
    output logic                                o_done,
    output logic signed [tatc_pkg::TEMP_W-1:0]  o_temp_centi,
    output logic [1:0]                          o_status,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [tatc_pkg::BIAS_W-1:0]         i_cfg_wdata
);

    localparam int AB   = tatc_pkg::ADC_BITS;
    localparam int NW   = tatc_pkg::NW;
    localparam int XW   = tatc_pkg::XW;
    localparam int LGW  = tatc_pkg::LGW;
    localparam int LFB  = tatc_pkg::LOG_FRAC_BITS;
    localparam int MVW  = tatc_pkg::MV_W;
    localparam int BW   = tatc_pkg::BIAS_W;
    localparam int DS   = tatc_pkg::DIV_STEPS;
    localparam int LAST = tatc_pkg::ST_OUT;
    localparam int TOW  = tatc_pkg::TEMP_W;

    localparam int QL   = 20;                  // fraction bits of ln(R)
    localparam int CBW  = 30;
    localparam int CCW  = 22;
    localparam int CAW  = 31;
    localparam int LMW  = LGW + 32 - (LFB + 12);
    localparam int L2W  = 2 * LMW - QL;
    localparam int TBW  = CBW + LMW - QL;
    localparam int L3W  = L2W + LMW - QL;
    localparam int L3H  = L3W / 2;
    localparam int L3U  = L3W - L3H;
    localparam int TCW  = CCW + L3W - QL;
    localparam int SW   = TCW + 2;
    localparam int RW   = SW + 1;
    localparam int NPW  = 48;
    localparam int QHW  = NPW - DS;
    localparam int TW   = DS + 1;
    localparam int XTW  = TW + 1;
    localparam int YW   = XTW + 4;
    localparam int RCW  = 20;
    localparam int RCS  = 22;
    localparam int F5W  = YW + RCW - RCS;

    localparam int ST_LOG = 2;

    localparam logic [1:0] REG_BIAS   = 2'd0;
    localparam logic [1:0] REG_SUPPLY = 2'd1;
    localparam logic [1:0] REG_FSCALE = 2'd2;
    localparam logic [1:0] REG_UNIT   = 2'd3;
    localparam logic [1:0] UNIT_KELVIN  = 2'd0;
    localparam logic [1:0] UNIT_CELSIUS = 2'd1;

    localparam logic [63:0]   DEC18    = 64'd1000000000000000000;
    localparam logic [AB-1:0] MAXC     = {AB{1'b1}};
    localparam logic [31:0]   LN2_Q32  = 32'd2977044472;
    localparam logic [NPW-1:0] CN      = NPW'(100) << 40;
    localparam logic [DS-1:0] Q_SAT    = DS'(1) << (DS - 1);
    localparam logic [RCW-1:0] RECIP5  = RCW'((2**RCS + 4) / 5);

    function automatic logic [63:0] dec_to_q40(input logic [63:0] dec);
        logic [63:0] d;
        logic [63:0] r;
        d = dec;
        r = '0;
        for (int i = 0; i < 40; i++) begin
            d = d << 1;
            r = r << 1;
            if (d >= DEC18) begin
                d = d - DEC18;
                r[0] = 1'b1;
            end
        end
        if ((d << 1) >= DEC18) r = r + 64'd1;
        return r;
    endfunction

    localparam logic [CAW-1:0] COEF_A = CAW'(dec_to_q40(64'd1592592214626784));
    localparam logic [CBW-1:0] COEF_B = CBW'(dec_to_q40(64'd820549188824018));
    localparam logic [CCW-1:0] COEF_C = CCW'(dec_to_q40(64'd2943849972756));

    // ---------------- configuration ----------------
    logic [BW-1:0]  r_bias;
    logic [MVW-1:0] r_supply;
    logic [MVW-1:0] r_fscale;
    logic [1:0]     r_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias   <= BW'(2700);
            r_supply <= MVW'(5000);
            r_fscale <= MVW'(5000);
            r_unit   <= 2'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BIAS:   r_bias   <= i_cfg_wdata;
                REG_SUPPLY: r_supply <= i_cfg_wdata[MVW-1:0];
                REG_FSCALE: r_fscale <= i_cfg_wdata[MVW-1:0];
                REG_UNIT:   r_unit   <= i_cfg_wdata[1:0];
                default:    r_unit   <= r_unit;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- valid and status line ----------------
    logic       r_vld  [0:LAST];
    logic [1:0] r_stat [ST_LOG:LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k <= LAST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---------------- front end: voltage and divider terms ----------------
    logic [AB-1:0] r_code;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_top;
    logic [XW-1:0] r_num;
    logic [XW-1:0] r_den;
    logic [BW-1:0] n_bias;

    assign n_bias = (r_bias == '0) ? BW'(1) : r_bias;

    always_ff @(posedge i_clk) begin
        r_code <= i_adc_code[AB-1:0];
        r_n    <= NW'(r_code) * NW'(r_fscale);
        r_top  <= NW'(r_supply) * NW'(MAXC);
        r_num  <= XW'(n_bias) * XW'(r_n);
        r_den  <= XW'(r_top - r_n);
        // classify the reading; the status rides with the beat from here on
        if (r_n == '0)
            r_stat[ST_LOG] <= tatc_pkg::STAT_ZERO;
        else if (r_n >= r_top)
            r_stat[ST_LOG] <= tatc_pkg::STAT_HIGH;
        else
            r_stat[ST_LOG] <= tatc_pkg::STAT_OK;
        for (int k = ST_LOG + 1; k <= LAST; k++) r_stat[k] <= r_stat[k-1];
    end

    // ---------------- log2 of numerator and denominator ----------------
    logic [LGW-1:0] w_lnum;
    logic [LGW-1:0] w_lden;

    tatc_log2 u_log_num (.i_clk(i_clk), .i_x(r_num), .o_log(w_lnum));
    tatc_log2 u_log_den (.i_clk(i_clk), .i_x(r_den), .o_log(w_lden));

    // ---------------- ln(R) and its powers ----------------
    logic [LGW:0]          n_diff;
    logic [LGW+32:0]       n_lp;
    logic [2*LMW-1:0]      n_l2p;
    logic [CBW+LMW-1:0]    n_tbp;
    logic [L2W+LMW-1:0]    n_l3p;
    logic [CCW+L3W-1:0]    n_tcp;

    logic [LGW-1:0]   r_dmag;
    logic             r_dneg;
    logic [LMW-1:0]   r_lmag;
    logic [LMW-1:0]   r_lmag_g;
    logic             r_lneg [0:4];
    logic [L2W-1:0]   r_l2;
    logic [TBW-1:0]   r_tb [0:3];
    logic [L3W-1:0]   r_l3;
    logic [CCW+L3H-1:0] r_ppl;
    logic [CCW+L3U-1:0] r_pph;
    logic [TCW-1:0]   r_tc;

    always_comb begin
        n_diff = {1'b0, w_lnum} - {1'b0, w_lden};
        n_lp   = (LGW+33)'(r_dmag) * (LGW+33)'(LN2_Q32) + ((LGW+33)'(1) << (LFB + 11));
        n_l2p  = (2*LMW)'(r_lmag) * (2*LMW)'(r_lmag);
        n_tbp  = (CBW+LMW)'(COEF_B) * (CBW+LMW)'(r_lmag);
        n_l3p  = (L2W+LMW)'(r_l2) * (L2W+LMW)'(r_lmag_g);
        n_tcp  = {r_pph, L3H'(0)} + (CCW+L3W)'(r_ppl);
    end

    always_ff @(posedge i_clk) begin
        r_dneg    <= n_diff[LGW];
        r_dmag    <= n_diff[LGW] ? LGW'(-n_diff) : n_diff[LGW-1:0];
        r_lmag    <= n_lp[LFB+12 +: LMW];
        r_lneg[0] <= r_dneg;
        r_l2      <= n_l2p[2*LMW-1:QL];
        r_tb[0]   <= n_tbp[CBW+LMW-1:QL];
        r_lmag_g  <= r_lmag;
        r_l3      <= n_l3p[L2W+LMW-1:QL];
        // split the cubic term so each partial product stays narrow
        r_ppl     <= (CCW+L3H)'(COEF_C) * (CCW+L3H)'(r_l3[L3H-1:0]);
        r_pph     <= (CCW+L3U)'(COEF_C) * (CCW+L3U)'(r_l3[L3W-1:L3H]);
        r_tc      <= n_tcp[CCW+L3W-1:QL];
        for (int k = 1; k <= 4; k++) r_lneg[k] <= r_lneg[k-1];
        for (int k = 1; k <= 3; k++) r_tb[k] <= r_tb[k-1];
    end

    // ---------------- curve sum and reciprocal setup ----------------
    logic [SW-1:0]  n_s;
    logic [SW-1:0]  r_s;
    logic [SW-1:0]  r_sabs;
    logic           r_sneg;
    logic           r_szero;
    logic [NPW-1:0] r_np;
    logic [SW-1:0]  r_dvl;
    logic           r_sneg_l;
    logic           r_szero_l;

    always_comb begin
        // B term follows the sign of ln(R); the C term has the opposite sign
        n_s = -SW'(COEF_A)
            + (r_lneg[4] ? -SW'(r_tb[3]) : SW'(r_tb[3]))
            + (r_lneg[4] ?  SW'(r_tc)    : -SW'(r_tc));
    end

    always_ff @(posedge i_clk) begin
        r_s       <= n_s;
        r_sneg    <= r_s[SW-1];
        r_szero   <= (r_s == '0);
        r_sabs    <= r_s[SW-1] ? -r_s : r_s;
        r_np      <= CN + NPW'(r_sabs >> 1);
        r_dvl     <= r_szero ? SW'(1) : r_sabs;
        r_sneg_l  <= r_sneg;
        r_szero_l <= r_szero;
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [RW-1:0] r_rem [0:DS-1];
    logic [DS-1:0] r_lo  [0:DS-1];
    logic [SW-1:0] r_dvs [0:DS-1];
    logic [DS-1:0] r_q   [0:DS];
    logic          r_ovf [0:DS];
    logic          r_sgn [0:DS];
    logic          r_szr [0:DS];
    logic [RW-1:0] n_trl [1:DS];
    logic          n_ge  [1:DS];
    logic [QHW-1:0] n_hi;

    always_comb begin
        n_hi = r_np[NPW-1:DS];
        for (int k = 1; k <= DS; k++) begin
            n_trl[k] = {r_rem[k-1][RW-2:0], r_lo[k-1][DS-1]};
            n_ge[k]  = n_trl[k] >= RW'(r_dvs[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        // quotient would not fit: flag it and clamp at the end
        r_ovf[0] <= RW'(n_hi) >= RW'(r_dvl);
        r_rem[0] <= (RW'(n_hi) >= RW'(r_dvl)) ? '0 : RW'(n_hi);
        r_lo[0]  <= r_np[DS-1:0];
        r_dvs[0] <= r_dvl;
        r_q[0]   <= '0;
        r_sgn[0] <= r_sneg_l;
        r_szr[0] <= r_szero_l;
        for (int k = 1; k < DS; k++) begin
            r_rem[k] <= n_ge[k] ? n_trl[k] - RW'(r_dvs[k-1]) : n_trl[k];
            r_lo[k]  <= r_lo[k-1] << 1;
            r_dvs[k] <= r_dvs[k-1];
        end
        for (int k = 1; k <= DS; k++) begin
            r_q[k]   <= {r_q[k-1][DS-2:0], n_ge[k]};
            r_ovf[k] <= r_ovf[k-1];
            r_sgn[k] <= r_sgn[k-1];
            r_szr[k] <= r_szr[k-1];
        end
    end

    // ---------------- unit conversion and saturation ----------------
    logic [DS-1:0]          n_tk;
    logic signed [TW-1:0]   r_t;
    logic signed [TW-1:0]   r_t2;
    logic signed [TW-1:0]   r_t3;
    logic signed [TW-1:0]   r_t4;
    logic signed [XTW-1:0]  r_x;
    logic signed [XTW-1:0]  r_x3;
    logic signed [XTW-1:0]  r_x4;
    logic signed [YW-1:0]   n_y;
    logic [YW-1:0]          r_ymag;
    logic                   r_yneg;
    logic                   r_yneg4;
    logic [YW+RCW-1:0]      n_fp;
    logic [F5W-1:0]         r_f5;
    logic signed [YW-1:0]   n_f;
    logic signed [YW-1:0]   n_sel;
    logic signed [TOW-1:0]  r_temp;

    always_comb begin
        if (r_szr[DS])
            n_tk = DS'(tatc_pkg::TEMP_MAX + 1);
        else if (r_ovf[DS])
            n_tk = Q_SAT;
        else
            n_tk = r_q[DS];
        n_y  = (YW'(r_x) <<< 3) + YW'(r_x);
        n_fp = (YW+RCW)'(r_ymag) * (YW+RCW)'(RECIP5);
        n_f  = (r_yneg4 ? -YW'(r_f5) : YW'(r_f5)) + YW'(3200);
        case (r_unit)
            UNIT_KELVIN:  n_sel = YW'(r_t4);
            UNIT_CELSIUS: n_sel = YW'(r_x4);
            default:      n_sel = n_f;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_t     <= r_sgn[DS] ? -TW'(n_tk) : TW'(n_tk);
        r_t2    <= r_t;
        r_x     <= XTW'(r_t) - XTW'(27315);
        r_t3    <= r_t2;
        r_x3    <= r_x;
        r_yneg  <= n_y[YW-1];
        r_ymag  <= (n_y[YW-1] ? YW'(-n_y) : YW'(n_y)) + YW'(2);
        r_t4    <= r_t3;
        r_x4    <= r_x3;
        r_yneg4 <= r_yneg;
        r_f5    <= n_fp[YW+RCW-1:RCS];
        // drop the value on an error reading, else clip to the output range
        if (r_stat[LAST-1] != tatc_pkg::STAT_OK)
            r_temp <= '0;
        else if (n_sel > YW'(tatc_pkg::TEMP_MAX))
            r_temp <= TOW'(tatc_pkg::TEMP_MAX);
        else if (n_sel < YW'(tatc_pkg::TEMP_MIN))
            r_temp <= TOW'(tatc_pkg::TEMP_MIN);
        else
            r_temp <= n_sel[TOW-1:0];
    end

    assign o_done       = r_vld[LAST];
    assign o_status     = r_stat[LAST];
    assign o_temp_centi = r_temp;

endmodule

FILE: rtl/tatc_checker.sv
// Port-level checker of the thermistor core, bound to the top level.
// Depends on tatc_pkg and thermistor_adc_to_temperature_core_defines.svh.
`include "thermistor_adc_to_temperature_core_defines.svh"

module tatc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_done,
    input logic signed [tatc_pkg::TEMP_W-1:0] o_temp_centi,
    input logic [1:0]                         o_status
);

    `TATC_ASSERT_DLY(a_result_follows, i_clk, i_rst_n, start && !busy, tatc_pkg::PIPE_LAT, o_done, "accepted beat gave no result")
    `TATC_ASSERT_DLY(a_no_phantom, i_clk, i_rst_n, !(start && !busy), tatc_pkg::PIPE_LAT, !o_done, "result without a beat")
    `TATC_ASSERT_IMP(a_error_zero, i_clk, i_rst_n, o_done && o_status != tatc_pkg::STAT_OK, o_temp_centi == '0, "error result with nonzero temperature")
    `TATC_ASSERT_IMP(a_range, i_clk, i_rst_n, o_done, (o_temp_centi <= tatc_pkg::TEMP_MAX) && (o_temp_centi >= tatc_pkg::TEMP_MIN) && (o_status != 2'd3), "result out of range")

endmodule

bind thermistor_adc_to_temperature_core tatc_checker u_tatc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_temp_centi (o_temp_centi),
    .o_status     (o_status)
);
